// ----- rtl/rmvn_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, types and constants of the ring mesh vertex normal block.
package rmvn_pkg;

   localparam int FACES_W = 10;
   localparam int LEVEL_W = 7;
   localparam int COL_W   = 9;
   localparam int POS_W   = 24;
   localparam int DIFF_W  = 25;
   localparam int MUL_W   = 32;
   localparam int PROD_W  = 64;
   localparam int CROSS_W = 52;
   localparam int MAG_W   = 51;
   localparam int SCL_W   = 31;
   localparam int SUM_W   = 64;
   localparam int ROOT_W  = 32;
   localparam int Q_W     = 16;
   localparam int Q_FRAC  = 14;
   localparam int NUM_W   = 46;
   localparam int NRM_W   = 16;

   localparam logic [FACES_W-1:0] FACES_RESET = 10'd360;
   localparam logic [Q_W-1:0]     Q_ONE       = 16'd16384;

   typedef enum logic {
      FUNC_WRITE   = 1'b0,
      FUNC_COMPUTE = 1'b1
   } func_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
   } vertex_type;

endpackage

// ----- rtl/rmvn_store.sv -----
`timescale 1ns / 1ps
// Single-port vertex position memory with a registered read.
module rmvn_store #(
   parameter int DEPTH = 65536,
   parameter int AW    = 16
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic                rd_en,
   input  logic [AW-1:0]       addr,
   input  rmvn_pkg::vertex_type wr_data,
   output rmvn_pkg::vertex_type rd_data
);
   import rmvn_pkg::*;

   vertex_type mem [DEPTH];
   vertex_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rmvn_sqrt.sv -----
`timescale 1ns / 1ps
// Bit-serial integer square root, one result bit per cycle.
module rmvn_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rmvn_pkg::SUM_W-1:0]    radicand,
   output logic                          done,
   output logic [rmvn_pkg::ROOT_W-1:0]   root
);
   import rmvn_pkg::*;

   logic [SUM_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0] res_ff, res_in;
   logic [SUM_W-1:0] step_ff, step_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [SUM_W-1:0] trial;

   always_comb begin
      trial   = res_ff + step_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = radicand;
         res_in  = '0;
         step_in = SUM_W'(1) << (SUM_W - 2);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + step_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         step_in = step_ff >> 2;
         if (step_ff == SUM_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = res_ff[ROOT_W-1:0];

endmodule

// ----- rtl/rmvn_div.sv -----
`timescale 1ns / 1ps
// Restoring divider for one Q1.14 magnitude, one quotient bit per cycle.
module rmvn_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rmvn_pkg::NUM_W-1:0]    num,
   input  logic [rmvn_pkg::ROOT_W-1:0]   den,
   output logic                          done,
   output logic [rmvn_pkg::Q_W-1:0]      quo
);
   import rmvn_pkg::*;

   localparam int CW = $clog2(Q_W + 1);

   logic [ROOT_W-1:0] rem_ff, rem_in;
   logic [Q_W-1:0]    low_ff, low_in;
   logic [Q_W-1:0]    quo_ff, quo_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ROOT_W:0]   trial;
   logic              fits;

   always_comb begin
      trial   = {rem_ff, low_ff[Q_W-1]};
      fits    = trial >= {1'b0, den};
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = ROOT_W'(num >> Q_W);
         low_in  = num[Q_W-1:0];
         quo_in  = '0;
         cnt_in  = CW'(Q_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? ROOT_W'(trial - {1'b0, den}) : trial[ROOT_W-1:0];
         quo_in = {quo_ff[Q_W-2:0], fits};
         low_in = low_ff << 1;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ----- rtl/ring_mesh_vertex_normal.sv -----
`timescale 1ns / 1ps
// Ring mesh vertex normal: position store and unit normal of a vertex.
//
// A request on the req_ channel either writes one vertex position (func 0)
// or asks for the unit normal at (level, column) (func 1). A write gives no
// response; a compute gives one response on the rsp_ channel with the
// Q1.14 normal and a degenerate flag. The csr_ channel writes
// faces_per_level and is always ready; write it only while idle.
// One request is worked on at a time. A compute runs through a range
// check, memory reads of the centre, next and previous points on the
// single port, the cross product on the shared 32x32 multiplier, the
// magnitudes, bit-serial scaling, the squares on the same multiplier,
// the bit-serial square root and three divisions; req_ready rises in the
// cycle that the response is shown. A zero cross product or an
// out-of-range request skips to the response with the degenerate flag
// set. The result sits in an output register, so a new request is taken
// while it waits for rsp_ready. Reset clears control and sets
// faces_per_level to 360; the position memory is not cleared.
module ring_mesh_vertex_normal #(
   parameter int MAX_FACES  = 512,
   parameter int MAX_LEVELS = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_func,
   input  logic [rmvn_pkg::LEVEL_W-1:0]        req_level,
   input  logic [rmvn_pkg::COL_W-1:0]          req_column,
   input  logic signed [rmvn_pkg::POS_W-1:0]   req_pos_x,
   input  logic signed [rmvn_pkg::POS_W-1:0]   req_pos_y,
   input  logic signed [rmvn_pkg::POS_W-1:0]   req_pos_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [rmvn_pkg::NRM_W-1:0]   rsp_normal_x,
   output logic signed [rmvn_pkg::NRM_W-1:0]   rsp_normal_y,
   output logic signed [rmvn_pkg::NRM_W-1:0]   rsp_normal_z,
   output logic                                rsp_degenerate,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rmvn_pkg::FACES_W-1:0]        csr_faces_per_level
);
   import rmvn_pkg::*;

   localparam int DEPTH = MAX_LEVELS * MAX_FACES;
   localparam int AW    = $clog2(DEPTH);

   typedef enum logic [3:0] {
      S_IDLE, S_WRITE, S_CHECK, S_RD_C, S_RD_N, S_RD_P, S_RD_W, S_CROSS,
      S_MAG, S_SCALE, S_SQUARE, S_ROOT_GO, S_ROOT, S_DIV_GO, S_DIV, S_OUT
   } state_type;

   function automatic logic [AW-1:0] vert_addr(input logic [LEVEL_W-1:0] lv,
                                                input logic [COL_W:0] col);
      vert_addr = AW'(32'(lv) * 32'(MAX_FACES) + 32'(col));
   endfunction

   state_type                 state_ff, state_in;
   logic [FACES_W-1:0]        faces_ff, faces_in;
   logic [LEVEL_W-1:0]        level_ff, level_in;
   logic [COL_W-1:0]          column_ff, column_in;
   vertex_type                pos_ff, pos_in;
   vertex_type                pt_c_ff, pt_c_in;
   logic signed [DIFF_W-1:0]  ux_ff, uy_ff, uz_ff, ux_in, uy_in, uz_in;
   logic signed [DIFF_W-1:0]  vx_ff, vy_ff, vz_ff, vx_in, vy_in, vz_in;
   logic [2:0]                cnt_ff, cnt_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [CROSS_W-1:0] cx_ff, cy_ff, cz_ff, cx_in, cy_in, cz_in;
   logic [MAG_W-1:0]          ax_ff, ay_ff, az_ff, ax_in, ay_in, az_in;
   logic [MAG_W-1:0]          m_ff, m_in;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic [ROOT_W-1:0]         len_ff, len_in;
   logic signed [NRM_W-1:0]   nx_ff, ny_ff, nz_ff, nx_in, ny_in, nz_in;
   logic                      degen_ff, degen_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [NRM_W-1:0]   rsp_x_ff, rsp_y_ff, rsp_z_ff, rsp_x_in, rsp_y_in, rsp_z_in;
   logic                      rsp_degen_ff, rsp_degen_in;

   logic [31:0]               faces_eff;
   logic [COL_W:0]            col_next, col_wrap;
   logic [LEVEL_W-1:0]        level_prev;
   logic                      write_ok, compute_ok;
   logic [AW-1:0]             addr_c, addr_n, addr_p, mem_addr;
   logic                      wr_en, rd_en;
   vertex_type                rd_data;
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [CROSS_W-1:0] prod_c;
   logic [MAG_W-1:0]          abs_x, abs_y, abs_z, abs_max;
   logic                      sqrt_start, sqrt_done;
   logic [ROOT_W-1:0]         sqrt_root;
   logic                      div_start, div_done;
   logic [Q_W-1:0]            div_quo, quo_sat, quo_mag;
   logic [NUM_W-1:0]          div_num;
   logic [MAG_W-1:0]          a_sel;
   logic                      neg_sel;
   logic signed [NRM_W-1:0]   n_val;

   rmvn_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .rd_en   (rd_en),
      .addr    (mem_addr),
      .wr_data (pos_ff),
      .rd_data (rd_data)
   );

   rmvn_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sum_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   rmvn_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (len_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      faces_eff  = (32'(faces_ff) > 32'(MAX_FACES)) ? 32'(MAX_FACES) : 32'(faces_ff);
      col_next   = {1'b0, column_ff} + (COL_W+1)'(1);
      col_wrap   = (32'(col_next) >= faces_eff) ? '0 : col_next;
      level_prev = (level_ff == '0) ? LEVEL_W'(1) : level_ff - LEVEL_W'(1);
      write_ok   = (32'(level_ff) < 32'(MAX_LEVELS)) && (32'(column_ff) < 32'(MAX_FACES));
      compute_ok = (32'(level_ff) < 32'(MAX_LEVELS)) && (32'(column_ff) < faces_eff);
      addr_c     = vert_addr(level_ff, {1'b0, column_ff});
      addr_n     = vert_addr(level_ff, col_wrap);
      addr_p     = vert_addr(level_prev, {1'b0, column_ff});

      prod_c  = CROSS_W'(prod_ff);
      abs_x   = MAG_W'(cx_ff[CROSS_W-1] ? -cx_ff : cx_ff);
      abs_y   = MAG_W'(cy_ff[CROSS_W-1] ? -cy_ff : cy_ff);
      abs_z   = MAG_W'(cz_ff[CROSS_W-1] ? -cz_ff : cz_ff);
      abs_max = (abs_x > abs_y) ? abs_x : abs_y;
      abs_max = (abs_z > abs_max) ? abs_z : abs_max;

      case (cnt_ff)
         3'd0: begin
            a_sel   = ax_ff;
            neg_sel = cx_ff[CROSS_W-1];
         end
         3'd1: begin
            a_sel   = ay_ff;
            neg_sel = cy_ff[CROSS_W-1];
         end
         default: begin
            a_sel   = az_ff;
            neg_sel = cz_ff[CROSS_W-1];
         end
      endcase
      div_num = (NUM_W'(a_sel[SCL_W-1:0]) << Q_FRAC) + NUM_W'(len_ff >> 1);
      quo_sat = (div_quo > Q_ONE) ? Q_ONE : div_quo;
      quo_mag = neg_sel ? -quo_sat : quo_sat;
      n_val   = quo_mag;
   end

   always_comb begin
      state_in     = state_ff;
      faces_in     = csr_valid ? csr_faces_per_level : faces_ff;
      level_in     = level_ff;
      column_in    = column_ff;
      pos_in       = pos_ff;
      pt_c_in      = pt_c_ff;
      ux_in        = ux_ff;
      uy_in        = uy_ff;
      uz_in        = uz_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      vz_in        = vz_ff;
      cnt_in       = cnt_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      az_in        = az_ff;
      m_in         = m_ff;
      sum_in       = sum_ff;
      len_in       = len_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      nz_in        = nz_ff;
      degen_in     = degen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_degen_in = rsp_degen_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      mem_addr     = addr_c;
      mul_a        = '0;
      mul_b        = '0;
      sqrt_start   = 1'b0;
      div_start    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               level_in  = req_level;
               column_in = req_column;
               pos_in    = '{x: req_pos_x, y: req_pos_y, z: req_pos_z};
               state_in  = (func_type'(req_func) == FUNC_WRITE) ? S_WRITE : S_CHECK;
            end
         end
         S_WRITE: begin
            wr_en    = write_ok;
            state_in = S_IDLE;
         end
         S_CHECK: begin
            if (compute_ok) begin
               state_in = S_RD_C;
            end else begin
               nx_in    = '0;
               ny_in    = '0;
               nz_in    = '0;
               degen_in = 1'b1;
               state_in = S_OUT;
            end
         end
         S_RD_C: begin
            rd_en    = 1'b1;
            state_in = S_RD_N;
         end
         S_RD_N: begin
            rd_en    = 1'b1;
            mem_addr = addr_n;
            pt_c_in  = rd_data;
            state_in = S_RD_P;
         end
         S_RD_P: begin
            rd_en    = 1'b1;
            mem_addr = addr_p;
            ux_in    = DIFF_W'($signed(rd_data.x)) - DIFF_W'($signed(pt_c_ff.x));
            uy_in    = DIFF_W'($signed(rd_data.y)) - DIFF_W'($signed(pt_c_ff.y));
            uz_in    = DIFF_W'($signed(rd_data.z)) - DIFF_W'($signed(pt_c_ff.z));
            state_in = S_RD_W;
         end
         S_RD_W: begin
            vx_in    = DIFF_W'($signed(rd_data.x)) - DIFF_W'($signed(pt_c_ff.x));
            vy_in    = DIFF_W'($signed(rd_data.y)) - DIFF_W'($signed(pt_c_ff.y));
            vz_in    = DIFF_W'($signed(rd_data.z)) - DIFF_W'($signed(pt_c_ff.z));
            cnt_in   = '0;
            state_in = S_CROSS;
         end
         S_CROSS: begin
            case (cnt_ff)
               3'd0: begin
                  mul_a = MUL_W'(uy_ff);
                  mul_b = MUL_W'(vz_ff);
               end
               3'd1: begin
                  mul_a = MUL_W'(uz_ff);
                  mul_b = MUL_W'(vy_ff);
               end
               3'd2: begin
                  mul_a = MUL_W'(uz_ff);
                  mul_b = MUL_W'(vx_ff);
               end
               3'd3: begin
                  mul_a = MUL_W'(ux_ff);
                  mul_b = MUL_W'(vz_ff);
               end
               3'd4: begin
                  mul_a = MUL_W'(ux_ff);
                  mul_b = MUL_W'(vy_ff);
               end
               3'd5: begin
                  mul_a = MUL_W'(uy_ff);
                  mul_b = MUL_W'(vx_ff);
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
            case (cnt_ff)
               3'd1:    cx_in = prod_c;
               3'd2:    cx_in = cx_ff - prod_c;
               3'd3:    cy_in = prod_c;
               3'd4:    cy_in = cy_ff - prod_c;
               3'd5:    cz_in = prod_c;
               3'd6:    cz_in = cz_ff - prod_c;
               default: cx_in = cx_ff;
            endcase
            if (cnt_ff == 3'd6) begin
               state_in = S_MAG;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         S_MAG: begin
            ax_in    = abs_x;
            ay_in    = abs_y;
            az_in    = abs_z;
            m_in     = abs_max;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            if (m_ff == '0) begin
               nx_in    = '0;
               ny_in    = '0;
               nz_in    = '0;
               degen_in = 1'b1;
               state_in = S_OUT;
            end else if (|m_ff[MAG_W-1:SCL_W]) begin
               m_in  = m_ff >> 1;
               ax_in = ax_ff >> 1;
               ay_in = ay_ff >> 1;
               az_in = az_ff >> 1;
            end else if (!m_ff[SCL_W-1]) begin
               m_in  = m_ff << 1;
               ax_in = ax_ff << 1;
               ay_in = ay_ff << 1;
               az_in = az_ff << 1;
            end else begin
               cnt_in   = '0;
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            mul_a = {1'b0, a_sel[SCL_W-1:0]};
            mul_b = {1'b0, a_sel[SCL_W-1:0]};
            case (cnt_ff)
               3'd1:    sum_in = SUM_W'(prod_ff);
               3'd2:    sum_in = sum_ff + SUM_W'(prod_ff);
               3'd3:    sum_in = sum_ff + SUM_W'(prod_ff);
               default: sum_in = sum_ff;
            endcase
            if (cnt_ff == 3'd3) begin
               state_in = S_ROOT_GO;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         S_ROOT_GO: begin
            sqrt_start = 1'b1;
            state_in   = S_ROOT;
         end
         S_ROOT: begin
            if (sqrt_done) begin
               len_in   = sqrt_root;
               cnt_in   = '0;
               state_in = S_DIV_GO;
            end
         end
         S_DIV_GO: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               case (cnt_ff)
                  3'd0:    nx_in = n_val;
                  3'd1:    ny_in = n_val;
                  default: nz_in = n_val;
               endcase
               if (cnt_ff == 3'd2) begin
                  degen_in = 1'b0;
                  state_in = S_OUT;
               end else begin
                  cnt_in   = cnt_ff + 3'd1;
                  state_in = S_DIV_GO;
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = nx_ff;
               rsp_y_in     = ny_ff;
               rsp_z_in     = nz_ff;
               rsp_degen_in = degen_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      level_ff     <= level_in;
      column_ff    <= column_in;
      pos_ff       <= pos_in;
      pt_c_ff      <= pt_c_in;
      ux_ff        <= ux_in;
      uy_ff        <= uy_in;
      uz_ff        <= uz_in;
      vx_ff        <= vx_in;
      vy_ff        <= vy_in;
      vz_ff        <= vz_in;
      cnt_ff       <= cnt_in;
      prod_ff      <= prod_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      cz_ff        <= cz_in;
      ax_ff        <= ax_in;
      ay_ff        <= ay_in;
      az_ff        <= az_in;
      m_ff         <= m_in;
      sum_ff       <= sum_in;
      len_ff       <= len_in;
      nx_ff        <= nx_in;
      ny_ff        <= ny_in;
      nz_ff        <= nz_in;
      degen_ff     <= degen_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_z_ff     <= rsp_z_in;
      rsp_degen_ff <= rsp_degen_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         faces_ff     <= FACES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         faces_ff     <= faces_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_normal_x   = rsp_x_ff;
   assign rsp_normal_y   = rsp_y_ff;
   assign rsp_normal_z   = rsp_z_ff;
   assign rsp_degenerate = rsp_degen_ff;

endmodule

// ----- sim/ring_mesh_vertex_normal_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the ring mesh vertex normal block.
module ring_mesh_vertex_normal_tb;
   import rmvn_pkg::*;

   localparam int STORE_FACES = 512;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int SETTLE      = 250;

   typedef struct packed {
      logic signed [NRM_W-1:0] nx;
      logic signed [NRM_W-1:0] ny;
      logic signed [NRM_W-1:0] nz;
      logic                    degenerate;
   } normal_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_func;
   logic [LEVEL_W-1:0]        req_level;
   logic [COL_W-1:0]          req_column;
   logic signed [POS_W-1:0]   req_pos_x;
   logic signed [POS_W-1:0]   req_pos_y;
   logic signed [POS_W-1:0]   req_pos_z;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [NRM_W-1:0]   rsp_normal_x;
   logic signed [NRM_W-1:0]   rsp_normal_y;
   logic signed [NRM_W-1:0]   rsp_normal_z;
   logic                      rsp_degenerate;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [FACES_W-1:0]        csr_faces_per_level;

   vertex_type      mesh_pos[int];
   normal_type      normal_q[$];
   logic [FACES_W-1:0] faces_reg;
   int              mismatches;
   int              cycles;
   int              burst_left;

   ring_mesh_vertex_normal dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_level(req_level), .req_column(req_column),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .rsp_normal_z(rsp_normal_z), .rsp_degenerate(rsp_degenerate),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_faces_per_level(csr_faces_per_level)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic logic signed [NRM_W-1:0] to_unit(longint c, longint unsigned a,
                                                       longint unsigned len);
      longint unsigned q;
      q = (a * 16384 + (len >> 1)) / len;
      if (q > 16384) q = 16384;
      return (c < 0) ? -NRM_W'(q) : NRM_W'(q);
   endfunction

   function automatic int eff_faces();
      return (faces_reg > STORE_FACES) ? STORE_FACES : int'(faces_reg);
   endfunction

   function automatic normal_type predict_normal(int lvl, int col);
      normal_type      r;
      int              f, nc, pl;
      vertex_type      c, n, p;
      longint          ux, uy, uz, vx, vy, vz, cx, cy, cz;
      longint unsigned ax, ay, az, m, s, len;
      r = '{nx: 0, ny: 0, nz: 0, degenerate: 1'b1};
      f = eff_faces();
      if (col >= f) return r;
      pl = (lvl == 0) ? 1 : lvl - 1;
      nc = (col + 1 >= f) ? 0 : col + 1;
      c = mesh_pos[lvl * STORE_FACES + col];
      n = mesh_pos[lvl * STORE_FACES + nc];
      p = mesh_pos[pl * STORE_FACES + col];
      ux = longint'(n.x) - longint'(c.x);
      uy = longint'(n.y) - longint'(c.y);
      uz = longint'(n.z) - longint'(c.z);
      vx = longint'(p.x) - longint'(c.x);
      vy = longint'(p.y) - longint'(c.y);
      vz = longint'(p.z) - longint'(c.z);
      cx = uy * vz - uz * vy;
      cy = uz * vx - ux * vz;
      cz = ux * vy - uy * vx;
      ax = (cx < 0) ? -cx : cx;
      ay = (cy < 0) ? -cy : cy;
      az = (cz < 0) ? -cz : cz;
      m = ax;
      if (ay > m) m = ay;
      if (az > m) m = az;
      if (m == 0) return r;
      while (m >= (64'd1 << 31)) begin
         m = m >> 1; ax = ax >> 1; ay = ay >> 1; az = az >> 1;
      end
      while (m < (64'd1 << 30)) begin
         m = m << 1; ax = ax << 1; ay = ay << 1; az = az << 1;
      end
      s = ax * ax + ay * ay + az * az;
      len = int_sqrt(s);
      if (len == 0) return r;
      r.nx = to_unit(cx, ax, len);
      r.ny = to_unit(cy, ay, len);
      r.nz = to_unit(cz, az, len);
      r.degenerate = 1'b0;
      return r;
   endfunction

   function automatic vertex_type rand_vertex(vertex_type base);
      vertex_type v;
      case ($urandom_range(0, 3))
         0: begin
            v.x = POS_W'($urandom); v.y = POS_W'($urandom); v.z = POS_W'($urandom);
         end
         1: v = base;
         2: begin
            v.x = base.x + POS_W'($urandom_range(0, 6)) - 3;
            v.y = base.y + POS_W'($urandom_range(0, 6)) - 3;
            v.z = base.z + POS_W'($urandom_range(0, 6)) - 3;
         end
         default: begin
            v.x = base.x + POS_W'($urandom_range(0, 131072)) - 65536;
            v.y = base.y + POS_W'($urandom_range(0, 131072)) - 65536;
            v.z = base.z + POS_W'($urandom_range(0, 131072)) - 65536;
         end
      endcase
      return v;
   endfunction

   function automatic vertex_type mk_vertex(int x, int y, int z);
      vertex_type v;
      v.x = POS_W'(x); v.y = POS_W'(y); v.z = POS_W'(z);
      return v;
   endfunction

   task automatic send_req(func_type f, int lvl, int col, vertex_type p);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_valid  <= 1'b1;
      req_func   <= f;
      req_level  <= LEVEL_W'(lvl);
      req_column <= COL_W'(col);
      req_pos_x  <= p.x;
      req_pos_y  <= p.y;
      req_pos_z  <= p.z;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      if (f == FUNC_WRITE)
         mesh_pos[lvl * STORE_FACES + col] = p;
      else
         normal_q.insert(normal_q.size(), predict_normal(lvl, col));
   endtask

   task automatic write_pos(int lvl, int col, vertex_type p);
      send_req(FUNC_WRITE, lvl, col, p);
   endtask

   task automatic compute_normal(int lvl, int col);
      send_req(FUNC_COMPUTE, lvl, col,
               mk_vertex($urandom, $urandom, $urandom));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      while (normal_q.size() != 0) @(posedge clock);
   endtask

   task automatic set_faces(int value);
      drain_results();
      repeat (SETTLE) @(posedge clock);
      csr_valid           <= 1'b1;
      csr_faces_per_level <= FACES_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      faces_reg = FACES_W'(value);
   endtask

   // write the three points of one vertex, the centre at a random place among them, then ask for its normal
   task automatic ring_vertex();
      int         f, lvl, col, nc, pl, order;
      vertex_type c, n, p;
      f = eff_faces();
      lvl = $urandom_range(0, 127);
      col = $urandom_range(0, f - 1);
      nc = (col + 1 >= f) ? 0 : col + 1;
      pl = (lvl == 0) ? 1 : lvl - 1;
      c = mk_vertex($urandom, $urandom, $urandom);
      n = rand_vertex(c);
      p = rand_vertex(c);
      order = $urandom_range(0, 2);
      if (order == 0) write_pos(lvl, col, c);
      write_pos(pl, col, p);
      if (order == 1) write_pos(lvl, col, c);
      write_pos(lvl, nc, n);
      if (order == 2) write_pos(lvl, col, c);
      compute_normal(lvl, col);
   endtask

   task automatic random_phase(int items);
      int start_q, sent, lvl, col, f;
      sent = 0;
      while (sent < items) begin
         f = eff_faces();
         case ($urandom_range(0, 9))
            0: begin
               if (f < STORE_FACES) begin
                  compute_normal($urandom_range(0, 127), $urandom_range(f, 511));
                  sent++;
               end
            end
            1: begin
               write_pos($urandom_range(0, 127), $urandom_range(0, 511),
                         mk_vertex($urandom, $urandom, $urandom));
               sent++;
            end
            default: begin
               if (f > 0) begin
                  ring_vertex();
                  sent += 4;
               end else begin
                  compute_normal($urandom_range(0, 127), $urandom_range(0, 511));
                  sent++;
               end
            end
         endcase
      end
   endtask

   task automatic test_directed();
      write_pos(0, 0, mk_vertex(-8388608, -8388608, -8388608));
      write_pos(0, 1, mk_vertex(8388607, -8388608, -8388608));
      write_pos(1, 0, mk_vertex(-8388608, 8388607, -8388608));
      compute_normal(0, 0);
      write_pos(127, 359, mk_vertex(0, 0, 0));
      write_pos(127, 0, mk_vertex(8388607, 8388607, 8388607));
      write_pos(126, 359, mk_vertex(-8388608, 0, 8388607));
      compute_normal(127, 359);
      compute_normal(5, 400);
      compute_normal(127, 511);
      write_pos(2, 5, mk_vertex(1, 1, 1));
      write_pos(2, 6, mk_vertex(1, 1, 1));
      write_pos(1, 5, mk_vertex(1, 1, 1));
      compute_normal(2, 5);
      write_pos(127, 511, mk_vertex(8388607, -8388608, 8388607));
      write_pos(3, 10, mk_vertex(0, 0, 0));
      write_pos(3, 11, mk_vertex(1, 0, 0));
      write_pos(2, 10, mk_vertex(0, 1, 0));
      compute_normal(3, 10);
   endtask

   task automatic test_small_rings();
      set_faces(3);
      random_phase(100);
      set_faces(7);
      random_phase(100);
   endtask

   task automatic test_tiny_rings();
      set_faces(0);
      random_phase(30);
      set_faces(1);
      random_phase(40);
   endtask

   task automatic test_full_rings();
      set_faces(1023);
      random_phase(150);
      drain_results();
      random_phase(150);
      set_faces(512);
      random_phase(200);
   endtask

   task automatic test_default_rings();
      set_faces(360);
      random_phase(260);
   endtask

   always @(posedge clock) begin
      normal_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (normal_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: %0d %0d %0d deg %0b", rsp_normal_x,
                        rsp_normal_y, rsp_normal_z, rsp_degenerate);
         end else begin
            want = normal_q.pop_front();
            if (rsp_normal_x !== want.nx || rsp_normal_y !== want.ny ||
                rsp_normal_z !== want.nz || rsp_degenerate !== want.degenerate) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %0d %0d %0d deg %0b, got %0d %0d %0d deg %0b",
                           want.nx, want.ny, want.nz, want.degenerate, rsp_normal_x,
                           rsp_normal_y, rsp_normal_z, rsp_degenerate);
            end
         end
      end
   end

   always @(posedge clock) begin
      int mode;
      mode = (cycles / 300) % 4;
      case (mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 1);
         2: rsp_ready <= ($urandom_range(0, 5) == 0);
         default: rsp_ready <= ((cycles % 7) < 4);
      endcase
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL ring_mesh_vertex_normal");
         $finish;
      end
   end

   initial begin
      mismatches = 0;
      cycles = 0;
      burst_left = 0;
      faces_reg = FACES_RESET;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_func <= FUNC_WRITE;
      req_level <= '0;
      req_column <= '0;
      req_pos_x <= '0;
      req_pos_y <= '0;
      req_pos_z <= '0;
      rsp_ready <= 1'b0;
      csr_valid <= 1'b0;
      csr_faces_per_level <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_small_rings();
      test_tiny_rings();
      test_full_rings();
      test_default_rings();
      drain_results();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0)
         $display("PASS ring_mesh_vertex_normal");
      else
         $display("FAIL ring_mesh_vertex_normal");
      $finish;
   end

endmodule
